FILE: rtl/core/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, defaults, operation codes and register indexes for the
// clamped-term PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // Fixed field widths
  localparam int GAIN_W     = 16;  // signed Q8.8 gains
  localparam int LIMIT_W    = 23;  // unsigned magnitude limits
  localparam int DRIVE_W    = 24;  // signed control output
  localparam int CFG_ADDR_W = 3;

  // Parameter defaults
  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  // Limit reset value: full scale
  localparam logic [LIMIT_W-1:0] LIMIT_RST = {LIMIT_W{1'b1}};

  // Operation codes carried on in_tuser
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_P_LIMIT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_I_LIMIT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_D_LIMIT = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_O_LIMIT = 3'd6;

endpackage

FILE: rtl/core/pid_controller_clamped_terms_core.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped_terms_core
// Positional PID step with per-term magnitude clamps and integral anti-windup.
// ----------------------------------------------------------------------------
// Sequence: a compute request runs the serial anti-windup divide (one bit per
//   cycle), the integral clamp, three passes through the single shared
//   multiplier (P, I and D terms) and the output clamp before out_tvalid.
//   With a zero integral gain the divide is skipped; a clear goes straight to the result.
// Flow: one request at a time; in_tready is high only while idle, so a new
//   request is taken only after the last result enters the output register.
// Reset: synchronous active-low; gains 0, limits full scale, history zero.
// ----------------------------------------------------------------------------
module pid_controller_clamped_terms_core
  import pidc_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  localparam int IN_DATA_W     = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // target, feedback (low to high)
  input  logic                  in_tuser,   // operation
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DRIVE_W-1:0]    out_tdata,  // drive
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [LIMIT_W-1:0]    cfg_wdata
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int ERR_W   = SW + 1;
  localparam int DIFF_W  = SW + 2;
  localparam int BOUND_W = LIMIT_W + GAIN_FRAC_BITS;
  localparam int INTEG_W = BOUND_W + 1;
  localparam int ISUM_W  = ((INTEG_W > ERR_W) ? INTEG_W : ERR_W) + 1;
  localparam int MA_W    = (INTEG_W > DIFF_W) ? INTEG_W : DIFF_W;
  localparam int PROD_W  = MA_W + GAIN_W;
  localparam int TERM_W  = LIMIT_W + 1;
  localparam int TSUM_W  = TERM_W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_INTEG, S_MUL_P, S_ACC_P, S_MUL_I, S_ACC_I,
    S_MUL_D, S_ACC_D, S_SUM, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [LIMIT_W-1:0]       p_lim_r, i_lim_r, d_lim_r, o_lim_r;

  // controller state and working registers
  logic signed [INTEG_W-1:0] integ_r,    integ_nxt;
  logic signed [ERR_W-1:0]   prev_err_r, prev_err_nxt;
  logic signed [ERR_W-1:0]   err_r,      err_nxt;
  logic signed [PROD_W-1:0]  prod_r,     prod_nxt;
  logic signed [TSUM_W-1:0]  sum_r,      sum_nxt;
  logic signed [DRIVE_W-1:0] res_r,      res_nxt;
  logic [DRIVE_W-1:0]        out_data_r, out_data_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic                      accept;
  logic signed [SW-1:0]      target, feedback;
  logic                      gain_i_zero;
  logic [GAIN_W-1:0]         gain_i_mag;
  logic                      div_start, div_done;
  logic [BOUND_W-1:0]        div_quo;

  assign accept      = in_tvalid && in_tready;
  assign target      = in_tdata[SW-1:0];
  assign feedback    = in_tdata[2*SW-1:SW];
  assign gain_i_zero = (gain_i_r == '0);
  assign gain_i_mag  = gain_i_r[GAIN_W-1] ? GAIN_W'(-gain_i_r) : gain_i_r;
  assign div_start   = accept && (in_tuser == OP_STEP) && !gain_i_zero;

  // anti-windup bound = (i_limit << frac) / |gain_i|
  pidc_div #(
    .NUM_W (BOUND_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .numer    (BOUND_W'(i_lim_r) << GAIN_FRAC_BITS),
    .denom    (gain_i_mag),
    .done     (div_done),
    .quotient (div_quo)
  );

  // integral update with clamp to the bound
  logic signed [ISUM_W-1:0] isum, bound_pos;
  logic signed [INTEG_W-1:0] integ_clamped;

  assign isum      = ISUM_W'(integ_r) + ISUM_W'(err_r);
  assign bound_pos = ISUM_W'($signed({1'b0, div_quo}));

  always_comb begin
    if (isum > bound_pos)       integ_clamped = INTEG_W'(bound_pos);
    else if (isum < -bound_pos) integ_clamped = INTEG_W'(-bound_pos);
    else                        integ_clamped = INTEG_W'(isum);
  end

  // shared multiplier operand select
  logic signed [DIFF_W-1:0] err_diff;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [GAIN_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;

  assign err_diff = DIFF_W'(err_r) - DIFF_W'(prev_err_r);

  always_comb begin
    unique case (state_r)
      S_MUL_I: begin
        mul_a = MA_W'(integ_r);
        mul_b = gain_i_r;
      end
      S_MUL_D: begin
        mul_a = MA_W'(err_diff);
        mul_b = gain_d_r;
      end
      default: begin
        mul_a = MA_W'(err_r);
        mul_b = gain_p_r;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // scale the product back and clamp it to the term limit
  logic [LIMIT_W-1:0]        term_lim;
  logic signed [PROD_W-1:0]  scaled, lim_ext;
  logic signed [TERM_W-1:0]  term;

  always_comb begin
    unique case (state_r)
      S_ACC_I: term_lim = i_lim_r;
      S_ACC_D: term_lim = d_lim_r;
      default: term_lim = p_lim_r;
    endcase
  end

  assign scaled  = prod_r >>> GAIN_FRAC_BITS;
  assign lim_ext = PROD_W'($signed({1'b0, term_lim}));

  always_comb begin
    if (scaled > lim_ext)       term = TERM_W'(lim_ext);
    else if (scaled < -lim_ext) term = TERM_W'(-lim_ext);
    else                        term = TERM_W'(scaled);
  end

  // final output clamp
  logic signed [TSUM_W-1:0] olim_ext;
  logic signed [DRIVE_W-1:0] sum_clamped;

  assign olim_ext = TSUM_W'($signed({1'b0, o_lim_r}));

  always_comb begin
    if (sum_r > olim_ext)       sum_clamped = DRIVE_W'(olim_ext);
    else if (sum_r < -olim_ext) sum_clamped = DRIVE_W'(-olim_ext);
    else                        sum_clamped = DRIVE_W'(sum_r);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    integ_nxt     = integ_r;
    prev_err_nxt  = prev_err_r;
    err_nxt       = err_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_tuser == OP_CLEAR) begin
            integ_nxt    = '0;
            prev_err_nxt = '0;
            res_nxt      = '0;
            state_nxt    = S_DONE;
          end else begin
            err_nxt = ERR_W'(target) - ERR_W'(feedback);
            sum_nxt = '0;
            if (gain_i_zero) begin
              integ_nxt = '0;
              state_nxt = S_MUL_P;
            end else begin
              state_nxt = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_INTEG;
      end
      S_INTEG: begin
        integ_nxt = integ_clamped;
        state_nxt = S_MUL_P;
      end
      S_MUL_P: begin
        prod_nxt  = mul_p;
        state_nxt = S_ACC_P;
      end
      S_ACC_P: begin
        sum_nxt   = sum_r + TSUM_W'(term);
        state_nxt = S_MUL_I;
      end
      S_MUL_I: begin
        prod_nxt  = mul_p;
        state_nxt = S_ACC_I;
      end
      S_ACC_I: begin
        sum_nxt   = sum_r + TSUM_W'(term);
        state_nxt = S_MUL_D;
      end
      S_MUL_D: begin
        prod_nxt  = mul_p;
        state_nxt = S_ACC_D;
      end
      S_ACC_D: begin
        sum_nxt   = sum_r + TSUM_W'(term);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        res_nxt      = sum_clamped;
        prev_err_nxt = err_r;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      prev_err_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      prev_err_r  <= prev_err_nxt;
    end
    err_r      <= err_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      p_lim_r  <= LIMIT_RST;
      i_lim_r  <= LIMIT_RST;
      d_lim_r  <= LIMIT_RST;
      o_lim_r  <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN_P:  gain_p_r <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:  gain_i_r <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:  gain_d_r <= cfg_wdata[GAIN_W-1:0];
        REG_P_LIMIT: p_lim_r  <= cfg_wdata;
        REG_I_LIMIT: i_lim_r  <= cfg_wdata;
        REG_D_LIMIT: d_lim_r  <= cfg_wdata;
        REG_O_LIMIT: o_lim_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/core/pidc_div.sv
// ----------------------------------------------------------------------------
// pidc_div
// Radix-2 restoring unsigned divider: NUM_W-bit numerator by a GAIN_W-bit
// divisor, one quotient bit per cycle, done pulses with quotient valid.
// ----------------------------------------------------------------------------
module pidc_div
  import pidc_pkg::*;
#(
  parameter int NUM_W = LIMIT_W + GAIN_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  numer,
  input  logic [GAIN_W-1:0] denom,
  output logic              done,
  output logic [NUM_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic              busy_r,  busy_nxt;
  logic              done_r,  done_nxt;
  logic [CNT_W-1:0]  cnt_r,   cnt_nxt;
  logic [NUM_W-1:0]  quo_r,   quo_nxt;
  logic [GAIN_W:0]   rem_r,   rem_nxt;
  logic [GAIN_W-1:0] den_r,   den_nxt;

  logic [GAIN_W:0]   shifted;
  logic [GAIN_W:0]   trial;

  // One restoring step: bring down next numerator bit, try subtract
  assign shifted = {rem_r[GAIN_W-1:0], quo_r[NUM_W-1]};
  assign trial   = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = numer;
      rem_nxt  = '0;
      den_nxt  = denom;
    end else if (busy_r) begin
      if (trial[GAIN_W]) begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: sim/pidc_drive_checker.sv
// ----------------------------------------------------------------------------
// pidc_drive_checker
// Watches the request, result and register-write ports of the clamped-term
// PID core. Keeps its own copy of the gains, limits, integral and last error,
// predicts the drive for every accepted request and compares it with each
// accepted result, oldest first.
// ----------------------------------------------------------------------------
module pidc_drive_checker
  import pidc_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int IN_DATA_W      = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // target, feedback (low to high)
  input  logic                  in_tuser,   // operation
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [DRIVE_W-1:0]    out_tdata,  // drive
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [LIMIT_W-1:0]    cfg_wdata,
  output int                    mismatches,
  output int                    outstanding
);

  // Shadow registers and loop history
  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic [LIMIT_W-1:0]       p_lim, i_lim, d_lim, o_lim;
  longint                   integ;     // 32-bit in hardware, never leaves that range
  longint                   last_err;  // 17-bit error of the previous step

  logic [DRIVE_W-1:0] drive_expected[$];
  int                 err_cnt = 0;

  assign mismatches = err_cnt;

  function automatic longint clamp_sym(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Exact product, then floor shift back to integer units
  function automatic longint scaled_product(input longint x,
                                            input logic signed [GAIN_W-1:0] g);
    return (x * longint'(g)) >>> GAIN_FRAC_BITS;
  endfunction

  // One controller step; updates the history and returns the drive
  function automatic logic [DRIVE_W-1:0] control_step(
    input logic                           op,
    input logic signed [SAMPLE_WIDTH-1:0] tgt,
    input logic signed [SAMPLE_WIDTH-1:0] fb
  );
    longint e, p, i, d, mag, bound;
    if (op == OP_CLEAR) begin
      integ    = 0;
      last_err = 0;
      return '0;
    end
    e = longint'(tgt) - longint'(fb);
    p = clamp_sym(scaled_product(e, kp), longint'(p_lim));
    // anti-windup: integral held within the range that keeps I under its limit
    if (ki != 0) begin
      mag   = (ki < 0) ? -longint'(ki) : longint'(ki);
      bound = (longint'(i_lim) << GAIN_FRAC_BITS) / mag;
      integ = clamp_sym(integ + e, bound);
    end else begin
      integ = 0;
    end
    i = clamp_sym(scaled_product(integ, ki), longint'(i_lim));
    d = clamp_sym(scaled_product(e - last_err, kd), longint'(d_lim));
    last_err = e;
    return DRIVE_W'(clamp_sym(p + i + d, longint'(o_lim)));
  endfunction

  always @(posedge clk) begin : watch
    logic [DRIVE_W-1:0] want;
    if (!rst_n) begin
      kp       = '0;
      ki       = '0;
      kd       = '0;
      p_lim    = LIMIT_RST;
      i_lim    = LIMIT_RST;
      d_lim    = LIMIT_RST;
      o_lim    = LIMIT_RST;
      integ    = 0;
      last_err = 0;
      drive_expected.delete();
      outstanding <= 0;
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_addr)
          REG_GAIN_P:  kp    = cfg_wdata[GAIN_W-1:0];
          REG_GAIN_I:  ki    = cfg_wdata[GAIN_W-1:0];
          REG_GAIN_D:  kd    = cfg_wdata[GAIN_W-1:0];
          REG_P_LIMIT: p_lim = cfg_wdata;
          REG_I_LIMIT: i_lim = cfg_wdata;
          REG_D_LIMIT: d_lim = cfg_wdata;
          REG_O_LIMIT: o_lim = cfg_wdata;
          default: ;
        endcase
      end

      // results belong to earlier requests, so compare before predicting
      if (out_tvalid && out_tready) begin
        if (drive_expected.size() == 0) begin
          if (err_cnt < 10)
            $display("[%0t] drive %0d arrived with no request pending",
                     $time, $signed(out_tdata));
          err_cnt++;
        end else begin
          want = drive_expected.pop_front();
          if (out_tdata !== want) begin
            if (err_cnt < 10)
              $display("[%0t] drive mismatch: expected %0d, got %0d",
                       $time, $signed(want), $signed(out_tdata));
            err_cnt++;
          end
        end
      end

      if (in_tvalid && in_tready)
        drive_expected.push_back(control_step(in_tuser,
                                              in_tdata[SAMPLE_WIDTH-1:0],
                                              in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]));

      outstanding <= drive_expected.size();
    end
  end

endmodule

FILE: sim/tb_pid_controller_clamped_terms_core.sv
// ----------------------------------------------------------------------------
// tb_pid_controller_clamped_terms_core
// Drives step and clear requests through the clamped-term PID core under
// a series of gain and limit settings: a short directed set (rails, zero
// limits, disabled integral, windup into the anti-windup bound) and then
// tracking-loop sequences with random content. Both stream sides idle at
// random and the result side holds off once for a long stretch. A checker
// beside the core predicts and compares every drive.
// ----------------------------------------------------------------------------
module tb_pid_controller_clamped_terms_core;
  import pidc_pkg::*;

  localparam int SAMPLE_W        = SAMPLE_WIDTH_DEF;
  localparam int IN_W            = ((2 * SAMPLE_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS    = 1930;
  localparam int LONG_HOLD       = 600;
  localparam int DRAIN_CYCLES    = 64;
  localparam int WATCHDOG_TICKS  = 4800000;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;  // no register here

  localparam logic [GAIN_W-1:0]   GAIN_MAX = 16'h7FFF;
  localparam logic [GAIN_W-1:0]   GAIN_MIN = 16'h8000;
  localparam logic [GAIN_W-1:0]   GAIN_ONE = 16'h0100;
  localparam logic [SAMPLE_W-1:0] S_MAX    = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] S_MIN    = 16'h8000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [DRIVE_W-1:0]    out_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [LIMIT_W-1:0]    cfg_wdata;

  int fail_count;
  int pending;
  bit hold_req   = 1'b0;
  bit hold_taken = 1'b0;

  pid_controller_clamped_terms_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  pidc_drive_checker drive_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (fail_count),
    .outstanding (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the core hangs
  initial begin
    #(WATCHDOG_TICKS);
    $display("tb_pid_controller_clamped_terms_core: done, errors");
    $finish;
  end

  // Mostly short gaps, a few long ones; none in calm stretches
  function automatic int idle_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rail_value();
    case ($urandom_range(0, 3))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return GAIN_MAX;
      1:       return GAIN_MIN;
      2:       return '0;
      3:       return GAIN_W'($urandom_range(1, 512));
      4:       return -GAIN_W'($urandom_range(1, 512));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    int w;
    w = $urandom_range(1, LIMIT_W);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LIMIT_RST;
      2, 3:    return LIMIT_W'($urandom_range(0, 1000));
      default: return LIMIT_W'($urandom_range(0, (1 << w) - 1));
    endcase
  endfunction

  // One request; returns after acceptance and the idle gap that follows
  task automatic send_sample(input logic op, input logic [SAMPLE_W-1:0] tgt,
                             input logic [SAMPLE_W-1:0] fb, input bit calm);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_W'({fb, tgt});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = idle_gap(calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [LIMIT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Full register set; gains carry junk in the unused upper bits
  task automatic load_settings(input logic [GAIN_W-1:0] gp, gi, gd,
                               input logic [LIMIT_W-1:0] pl, il, dl, ol);
    write_reg(REG_SPARE, LIMIT_W'($urandom));
    write_reg(REG_GAIN_P, {7'($urandom), gp});
    write_reg(REG_GAIN_I, {7'($urandom), gi});
    write_reg(REG_GAIN_D, {7'($urandom), gd});
    write_reg(REG_P_LIMIT, pl);
    write_reg(REG_I_LIMIT, il);
    write_reg(REG_D_LIMIT, dl);
    write_reg(REG_O_LIMIT, ol);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering and wait for every predicted drive to come back
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Result side: ready stretches, random stalls, one long hold-off
  initial begin : result_sink
    int span;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      span = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 40);
      out_tready <= 1'b1;
      repeat (span) @(posedge clk);
      span = $urandom_range(0, 99);
      span = (span < 40) ? 0 : (span < 90) ? $urandom_range(1, 3) : $urandom_range(15, 50);
      if (span > 0) begin
        out_tready <= 1'b0;
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int          done_items, phase_items, k, r, meas, delta;
    bit          calm;
    logic [SAMPLE_W-1:0] set_pt;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_STEP;
    cfg_we    = 1'b0;
    cfg_addr  = REG_GAIN_P;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gains are zero: drive stays zero at the rails
    send_sample(OP_STEP, S_MAX, S_MIN, 1'b0);
    send_sample(OP_STEP, S_MIN, S_MAX, 1'b0);
    send_sample(OP_CLEAR, S_MAX, S_MAX, 1'b0);
    settle();

    // extreme gains, full limits: integral winds into its bound
    load_settings(GAIN_MAX, GAIN_MIN, GAIN_MAX, LIMIT_RST, LIMIT_RST, LIMIT_RST,
                  LIMIT_RST);
    repeat (4) send_sample(OP_STEP, S_MAX, S_MIN, 1'b0);
    repeat (2) send_sample(OP_STEP, S_MIN, S_MAX, 1'b0);
    send_sample(OP_STEP, '0, '0, 1'b0);
    send_sample(OP_CLEAR, S_MIN, S_MAX, 1'b0);
    send_sample(OP_STEP, 16'd1, '0, 1'b0);
    settle();

    // zero term limits force every term to zero
    load_settings(GAIN_MIN, 16'h0001, GAIN_MIN, '0, '0, '0, LIMIT_RST);
    send_sample(OP_STEP, S_MAX, S_MIN, 1'b0);
    send_sample(OP_STEP, S_MIN, 16'h1234, 1'b0);
    send_sample(OP_STEP, '1, S_MAX, 1'b0);
    settle();

    // small integral gain, tight integral limit, history kept across writes
    load_settings(GAIN_ONE, 16'h0001, GAIN_MIN, LIMIT_RST, 23'd500, LIMIT_RST,
                  LIMIT_RST);
    repeat (3) send_sample(OP_STEP, 16'd20000, S_MIN, 1'b0);
    settle();

    // integral gain zero clears the accumulated integral
    load_settings('1, '0, 16'h0001, LIMIT_RST, LIMIT_RST, LIMIT_RST, 23'd100000);
    send_sample(OP_STEP, 16'd300, 16'd100, 1'b0);
    send_sample(OP_STEP, S_MIN, S_MAX, 1'b0);
    settle();

    // zero output limit
    load_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, LIMIT_RST, LIMIT_RST, LIMIT_RST,
                  '0);
    send_sample(OP_STEP, S_MAX, S_MIN, 1'b0);
    send_sample(OP_STEP, S_MIN, S_MAX, 1'b0);
    settle();

    // tracking-loop sequences under random settings
    hold_req   = 1'b1;
    done_items = 0;
    set_pt     = '0;
    meas       = 0;
    while (done_items < RANDOM_ITEMS) begin
      load_settings(pick_gain(), pick_gain(), pick_gain(), pick_limit(),
                    pick_limit(), pick_limit(), pick_limit());
      calm        = ($urandom_range(0, 3) == 0);
      phase_items = $urandom_range(40, 240);
      if (phase_items > RANDOM_ITEMS - done_items)
        phase_items = RANDOM_ITEMS - done_items;
      for (k = 0; k < phase_items; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_sample(OP_CLEAR, SAMPLE_W'($urandom), SAMPLE_W'($urandom), calm);
        end else begin
          if (r < 8) begin
            set_pt = SAMPLE_W'($urandom);
            meas   = $signed(SAMPLE_W'($urandom));
          end else if (r < 12) begin
            set_pt = rail_value();
            meas   = $signed(rail_value());
          end else begin
            if (r < 16) set_pt = SAMPLE_W'($urandom);
            // feedback wanders by steps of varying size
            delta = $urandom_range(0, 1 << $urandom_range(0, 12));
            meas  = $urandom_range(0, 1) ? meas + delta : meas - delta;
            if (meas > 32767) meas = 32767;
            if (meas < -32768) meas = -32768;
          end
          send_sample(OP_STEP, set_pt, SAMPLE_W'(meas), calm);
        end
      end
      done_items += phase_items;
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_pid_controller_clamped_terms_core: done, clean");
    else
      $display("tb_pid_controller_clamped_terms_core: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/pidc_pkg.sv
rtl/core/pidc_div.sv
rtl/core/pid_controller_clamped_terms_core.sv
sim/pidc_drive_checker.sv
sim/tb_pid_controller_clamped_terms_core.sv
